### sv/assert_macros.svh
// assertion macros shared by the condenser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, clocked on clk and held off during reset
`define SCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication, clocked on clk and held off during reset
`define SCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### sv/scc_pkg.sv
// shared types, codes and fixed-point helpers of the condenser
`timescale 1ns / 1ps
package scc_pkg;

	localparam int FIRST_DOFS_DEF  = 4;
	localparam int SECOND_DOFS_DEF = 2;
	localparam int Q_W   = 32;
	localparam int ACC_W = 52;

	localparam logic [3:0] KIND_K        = 4'd0;
	localparam logic [3:0] KIND_G        = 4'd1;
	localparam logic [3:0] KIND_M        = 4'd2;
	localparam logic [3:0] KIND_F        = 4'd3;
	localparam logic [3:0] KIND_H        = 4'd4;
	localparam logic [3:0] KIND_D        = 4'd5;
	localparam logic [3:0] KIND_CONDENSE = 4'd6;
	localparam logic [3:0] KIND_RECOVER  = 4'd7;
	localparam logic [3:0] KIND_CLEAR    = 4'd8;

	localparam logic [1:0] TGT_MAT = 2'd0;
	localparam logic [1:0] TGT_VEC = 2'd1;
	localparam logic [1:0] TGT_DOF = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_RHS, S_PIVI, S_PIV, S_CHK, S_SWAP,
		S_DIVS, S_DIVW, S_ELIMF, S_ELIM, S_OUT, S_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] v);
		mag32 = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
	endfunction

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (&v[ACC_W-1:Q_W-1] || ~|v[ACC_W-1:Q_W-1])
			sat32 = v[Q_W-1:0];
		else if (v[ACC_W-1])
			sat32 = {1'b1, {(Q_W-1){1'b0}}};
		else
			sat32 = {1'b0, {(Q_W-1){1'b1}}};
	endfunction

endpackage

### sv/scc_if.sv
// handshake channels for command words and result words
`timescale 1ns / 1ps
interface scc_in_if;
	logic              valid;
	logic              ready;
	logic [3:0]        kind;
	logic [2:0]        row;
	logic [2:0]        col;
	logic signed [31:0] value;
	modport source(output valid, kind, row, col, value, input ready);
	modport sink(input valid, kind, row, col, value, output ready);
endinterface

interface scc_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        target;
	logic [2:0]        out_row;
	logic [2:0]        out_col;
	logic signed [31:0] result;
	logic              singular;
	logic              last;
	modport source(output valid, target, out_row, out_col, result, singular, last,
		input ready);
	modport sink(input valid, target, out_row, out_col, result, singular, last,
		output ready);
endinterface

### sv/scc_div.sv
// bit-serial q16.16 divider, rounds to nearest with ties away from zero, saturates
`timescale 1ns / 1ps
module scc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [31:0]      num,
	input  logic signed [31:0]      den,
	output logic signed [31:0]      quo,
	output scc_pkg::div_stat_t      stat
);
	localparam int DV_W = 49;
	localparam logic [5:0] STEPS = 6'(DV_W);

	logic [DV_W-1:0] dvd_q;
	logic [DV_W-1:0] quo_q;
	logic [32:0]     den2_q;
	logic [32:0]     rem_q;
	logic [5:0]      cnt_q;
	logic            neg_q;
	logic            done_q;
	logic [33:0]     trial;
	logic            qbit;
	logic [33:0]     diff;

	assign trial = {rem_q, dvd_q[DV_W-1]};
	assign qbit  = trial >= {1'b0, den2_q};
	assign diff  = trial - {1'b0, den2_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// (2|a|<<16 + |b|) / (2|b|) gives the rounded quotient
			dvd_q  <= {scc_pkg::mag32(num), 17'd0} + {17'd0, scc_pkg::mag32(den)};
			den2_q <= {scc_pkg::mag32(den), 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= num[31] ^ den[31];
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DV_W-2:0], 1'b0};
			quo_q <= {quo_q[DV_W-2:0], qbit};
			rem_q <= qbit ? diff[32:0] : trial[32:0];
		end
	end

	always_comb begin
		if (neg_q)
			quo = (quo_q > DV_W'(33'h080000000)) ? 32'sh80000000 : -signed'(quo_q[31:0]);
		else
			quo = (quo_q > DV_W'(32'h7fffffff)) ? 32'sh7fffffff : signed'(quo_q[31:0]);
	end

	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule

### sv/schur_complement_condenser.sv
// static condensation of a two-block system by gauss-jordan on a shared mac and divider
//
//  channel | dir | words
//  cmd     | in  | kind, row, col, value: loads, condense, recover, clear
//  res     | out | target, out_row, out_col, result, singular, last
//
// load, clear and unused kinds are taken in idle and leave the sequencer there.
// a run fills the working matrix (recover also forms its rhs from h, g and d), then per
// pivot column it searches for the pivot, swaps rows when needed, divides the pivot row
// from the pivot column on and eliminates the other rows; the 49-step divider dominates.
// condense then forms each result word on the mac, recover reads its words from the matrix.
// arst_n clears every store and the sequencer; cmd.ready is low during a run.
// a stalled res holds the sequencer in its emit step; the next cmd is taken while the
// final word of a run still waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module schur_complement_condenser #(
	parameter int FIRST_DOFS  = scc_pkg::FIRST_DOFS_DEF,
	parameter int SECOND_DOFS = scc_pkg::SECOND_DOFS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	scc_in_if.sink     cmd,
	scc_out_if.source  res
);
	localparam int ACC_W = scc_pkg::ACC_W;
	localparam int WC    = SECOND_DOFS + FIRST_DOFS + 1;
	localparam int N1_IW = (FIRST_DOFS > 1) ? $clog2(FIRST_DOFS) : 1;
	localparam int N2_IW = (SECOND_DOFS > 1) ? $clog2(SECOND_DOFS) : 1;
	localparam int WC_IW = $clog2(WC);
	localparam int CT_W  = $clog2(WC + 1);
	localparam logic [CT_W-1:0] N1_LAST = CT_W'(FIRST_DOFS - 1);
	localparam logic [CT_W-1:0] N2_LAST = CT_W'(SECOND_DOFS - 1);
	localparam logic [CT_W-1:0] N2_CNT  = CT_W'(SECOND_DOFS);
	localparam logic [CT_W-1:0] N12_CNT = CT_W'(SECOND_DOFS + FIRST_DOFS);
	localparam logic [CT_W-1:0] WC_LAST = CT_W'(WC - 1);

	// stores
	logic signed [31:0] k_q  [FIRST_DOFS][FIRST_DOFS];
	logic signed [31:0] g_q  [FIRST_DOFS][SECOND_DOFS];
	logic signed [31:0] m_q  [SECOND_DOFS][SECOND_DOFS];
	logic signed [31:0] fv_q [FIRST_DOFS];
	logic signed [31:0] hv_q [SECOND_DOFS];
	logic signed [31:0] dv_q [FIRST_DOFS];
	// augmented working matrix
	logic signed [31:0] w_q  [SECOND_DOFS][WC];

	scc_pkg::state_t state_q, state_d;
	logic            cond_q;
	logic            sing_q;
	logic            ph_q;
	logic [CT_W-1:0] i_q, j_q, k_q_idx, r_q, c_q, p_q, wlast_q;
	logic [1:0]      tgt_q;
	logic signed [31:0]      piv_q, fac_q, acc_res_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [63:0]        prod_s1;
	logic               neg_s1;
	logic signed [31:0] mul_a, mul_b;
	logic [63:0]        rsum;
	logic signed [ACC_W-1:0] rnd, nacc;

	logic               acc_in, out_free, last_now;
	logic signed [31:0] w_cj, w_rj, w_pj, w_rc, w_pc, w_kcol, load_val;
	logic [CT_W-1:0]    kcol;
	logic [CT_W-1:0]    ni, nj;
	logic [1:0]         ntgt;
	logic               emit_fire;

	logic               res_valid_q, res_sing_q, res_last_q;
	logic [1:0]         res_tgt_q;
	logic [2:0]         res_row_q, res_col_q;
	logic signed [31:0] res_val_q;

	logic               div_start;
	logic signed [31:0] div_quo;
	scc_pkg::div_stat_t div_st;

	scc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (w_cj),
		.den   (piv_q),
		.quo   (div_quo),
		.stat  (div_st)
	);

	assign acc_in   = cmd.valid & cmd.ready;
	assign out_free = !res_valid_q || res.ready;

	// working matrix taps
	assign w_cj = w_q[c_q[N2_IW-1:0]][j_q[WC_IW-1:0]];
	assign w_rj = w_q[r_q[N2_IW-1:0]][j_q[WC_IW-1:0]];
	assign w_pj = w_q[p_q[N2_IW-1:0]][j_q[WC_IW-1:0]];
	assign w_rc = w_q[r_q[N2_IW-1:0]][c_q[WC_IW-1:0]];
	assign w_pc = w_q[p_q[N2_IW-1:0]][c_q[WC_IW-1:0]];
	assign kcol = (tgt_q == scc_pkg::TGT_MAT) ? CT_W'(j_q + N2_CNT) : N12_CNT;
	assign w_kcol = w_q[k_q_idx[N2_IW-1:0]][kcol[WC_IW-1:0]];

	always_comb begin
		if (j_q < N2_CNT)
			load_val = m_q[r_q[N2_IW-1:0]][j_q[N2_IW-1:0]];
		else if (!cond_q)
			load_val = '0;
		else if (j_q < N12_CNT)
			load_val = g_q[N1_IW'(j_q - N2_CNT)][r_q[N2_IW-1:0]];
		else
			load_val = hv_q[r_q[N2_IW-1:0]];
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			scc_pkg::S_RHS: begin
				mul_a = g_q[i_q[N1_IW-1:0]][k_q_idx[N2_IW-1:0]];
				mul_b = dv_q[i_q[N1_IW-1:0]];
			end
			scc_pkg::S_ELIM: begin
				mul_a = fac_q;
				mul_b = w_cj;
			end
			scc_pkg::S_OUT: begin
				mul_a = g_q[i_q[N1_IW-1:0]][k_q_idx[N2_IW-1:0]];
				mul_b = sing_q ? 32'sd0 : w_kcol;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= scc_pkg::mag32(mul_a) * scc_pkg::mag32(mul_b);
		neg_s1  <= mul_a[31] ^ mul_b[31];
	end

	assign rsum = prod_s1 + 64'd32768;
	assign rnd  = neg_s1 ? -signed'(ACC_W'(rsum[63:16])) : signed'(ACC_W'(rsum[63:16]));
	assign nacc = acc_q - rnd;

	// result walk
	always_comb begin
		ni   = i_q;
		nj   = j_q;
		ntgt = tgt_q;
		if (tgt_q == scc_pkg::TGT_MAT) begin
			if (j_q == N1_LAST) begin
				nj = '0;
				if (i_q == N1_LAST) begin
					ntgt = scc_pkg::TGT_VEC;
					ni   = '0;
				end else begin
					ni = i_q + 1'b1;
				end
			end else begin
				nj = j_q + 1'b1;
			end
		end else begin
			ni = i_q + 1'b1;
		end
	end

	assign last_now  = cond_q ? (tgt_q == scc_pkg::TGT_VEC && i_q == N1_LAST)
	                          : (k_q_idx == N2_LAST);
	assign emit_fire = (state_q == scc_pkg::S_EMIT) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scc_pkg::S_IDLE:
				if (acc_in && (cmd.kind == scc_pkg::KIND_CONDENSE ||
				               cmd.kind == scc_pkg::KIND_RECOVER))
					state_d = scc_pkg::S_LOAD;
			scc_pkg::S_LOAD:
				if (r_q == N2_LAST && j_q == WC_LAST)
					state_d = cond_q ? scc_pkg::S_PIVI : scc_pkg::S_RHS;
			scc_pkg::S_RHS:
				if (ph_q && i_q == N1_LAST && k_q_idx == N2_LAST)
					state_d = scc_pkg::S_PIVI;
			scc_pkg::S_PIVI:
				state_d = scc_pkg::S_PIV;
			scc_pkg::S_PIV:
				if (r_q >= N2_CNT)
					state_d = scc_pkg::S_CHK;
			scc_pkg::S_CHK:
				if (w_pc == '0)
					state_d = cond_q ? scc_pkg::S_OUT : scc_pkg::S_EMIT;
				else if (p_q != c_q)
					state_d = scc_pkg::S_SWAP;
				else
					state_d = scc_pkg::S_DIVS;
			scc_pkg::S_SWAP:
				if (j_q == WC_LAST)
					state_d = scc_pkg::S_DIVS;
			scc_pkg::S_DIVS:
				state_d = scc_pkg::S_DIVW;
			scc_pkg::S_DIVW:
				if (div_st.done)
					state_d = (j_q == wlast_q) ? scc_pkg::S_ELIMF : scc_pkg::S_DIVS;
			scc_pkg::S_ELIMF:
				if (r_q >= N2_CNT) begin
					if (c_q == N2_LAST)
						state_d = cond_q ? scc_pkg::S_OUT : scc_pkg::S_EMIT;
					else
						state_d = scc_pkg::S_PIVI;
				end else if (r_q != c_q) begin
					state_d = scc_pkg::S_ELIM;
				end
			scc_pkg::S_ELIM:
				if (ph_q && j_q == wlast_q)
					state_d = scc_pkg::S_ELIMF;
			scc_pkg::S_OUT:
				if (ph_q && k_q_idx == N2_LAST)
					state_d = scc_pkg::S_EMIT;
			scc_pkg::S_EMIT:
				if (out_free)
					state_d = last_now ? scc_pkg::S_IDLE
					        : (cond_q ? scc_pkg::S_OUT : scc_pkg::S_EMIT);
			default:
				state_d = scc_pkg::S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		cmd.ready = state_q == scc_pkg::S_IDLE;
		div_start = state_q == scc_pkg::S_DIVS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scc_pkg::S_IDLE;
			res_valid_q <= 1'b0;
			cond_q      <= 1'b0;
			sing_q      <= 1'b0;
			ph_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			if (state_q == scc_pkg::S_IDLE && acc_in) begin
				cond_q <= cmd.kind == scc_pkg::KIND_CONDENSE;
				sing_q <= 1'b0;
			end
			if (state_q == scc_pkg::S_CHK && w_pc == '0)
				sing_q <= 1'b1;
			if (state_q == scc_pkg::S_RHS || state_q == scc_pkg::S_ELIM ||
			    state_q == scc_pkg::S_OUT)
				ph_q <= !ph_q;
			else
				ph_q <= 1'b0;
		end
	end

	// sequencer counters and datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			scc_pkg::S_IDLE: begin
				r_q     <= '0;
				j_q     <= '0;
				c_q     <= '0;
				wlast_q <= (cmd.kind == scc_pkg::KIND_CONDENSE) ? N12_CNT : N2_CNT;
			end
			scc_pkg::S_LOAD: begin
				w_q[r_q[N2_IW-1:0]][j_q[WC_IW-1:0]] <= load_val;
				if (j_q == WC_LAST) begin
					j_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
				i_q     <= '0;
				k_q_idx <= '0;
				acc_q   <= ACC_W'(hv_q[0]);
			end
			scc_pkg::S_RHS:
				if (ph_q) begin
					if (i_q == N1_LAST) begin
						w_q[k_q_idx[N2_IW-1:0]][N2_CNT[WC_IW-1:0]] <= scc_pkg::sat32(nacc);
						i_q     <= '0;
						k_q_idx <= k_q_idx + 1'b1;
						acc_q   <= ACC_W'(hv_q[N2_IW'(k_q_idx + 1'b1)]);
					end else begin
						i_q   <= i_q + 1'b1;
						acc_q <= nacc;
					end
				end
			scc_pkg::S_PIVI: begin
				p_q <= c_q;
				r_q <= c_q + 1'b1;
			end
			scc_pkg::S_PIV:
				if (r_q < N2_CNT) begin
					if (scc_pkg::mag32(w_rc) > scc_pkg::mag32(w_pc))
						p_q <= r_q;
					r_q <= r_q + 1'b1;
				end
			scc_pkg::S_CHK: begin
				piv_q <= w_pc;
				if (w_pc != '0)
					j_q <= (p_q != c_q) ? '0 : c_q;
			end
			scc_pkg::S_SWAP: begin
				w_q[p_q[N2_IW-1:0]][j_q[WC_IW-1:0]] <= w_cj;
				w_q[c_q[N2_IW-1:0]][j_q[WC_IW-1:0]] <= w_pj;
				j_q <= (j_q == WC_LAST) ? c_q : j_q + 1'b1;
			end
			scc_pkg::S_DIVS: ;
			scc_pkg::S_DIVW:
				if (div_st.done) begin
					w_q[c_q[N2_IW-1:0]][j_q[WC_IW-1:0]] <= div_quo;
					if (j_q == wlast_q)
						r_q <= '0;
					else
						j_q <= j_q + 1'b1;
				end
			scc_pkg::S_ELIMF:
				if (r_q >= N2_CNT) begin
					c_q <= c_q + 1'b1;
				end else if (r_q == c_q) begin
					r_q <= r_q + 1'b1;
				end else begin
					fac_q <= w_rc;
					j_q   <= c_q;
				end
			scc_pkg::S_ELIM:
				if (ph_q) begin
					w_q[r_q[N2_IW-1:0]][j_q[WC_IW-1:0]] <=
						scc_pkg::sat32({{(ACC_W-32){w_rj[31]}}, w_rj} - rnd);
					if (j_q == wlast_q)
						r_q <= r_q + 1'b1;
					else
						j_q <= j_q + 1'b1;
				end
			scc_pkg::S_OUT:
				if (ph_q) begin
					acc_q <= nacc;
					if (k_q_idx == N2_LAST)
						acc_res_q <= scc_pkg::sat32(nacc);
					else
						k_q_idx <= k_q_idx + 1'b1;
				end
			scc_pkg::S_EMIT:
				if (out_free) begin
					res_tgt_q  <= cond_q ? tgt_q : scc_pkg::TGT_DOF;
					res_row_q  <= cond_q ? 3'(i_q) : 3'(k_q_idx);
					res_col_q  <= (cond_q && tgt_q == scc_pkg::TGT_MAT) ? 3'(j_q) : 3'd0;
					res_val_q  <= cond_q ? acc_res_q
					            : (sing_q ? 32'sd0 : w_q[k_q_idx[N2_IW-1:0]][N2_CNT[WC_IW-1:0]]);
					res_sing_q <= sing_q;
					res_last_q <= last_now;
					if (cond_q) begin
						i_q     <= ni;
						j_q     <= nj;
						tgt_q   <= ntgt;
						k_q_idx <= '0;
						acc_q   <= (ntgt == scc_pkg::TGT_MAT)
						         ? ACC_W'(k_q[ni[N1_IW-1:0]][nj[N1_IW-1:0]])
						         : ACC_W'(fv_q[ni[N1_IW-1:0]]);
					end else begin
						k_q_idx <= k_q_idx + 1'b1;
					end
				end
			default: ;
		endcase
		// set up the result walk when the solve ends
		if (state_q != scc_pkg::S_OUT && state_q != scc_pkg::S_EMIT &&
		    (state_d == scc_pkg::S_OUT || state_d == scc_pkg::S_EMIT)) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q_idx <= '0;
			tgt_q   <= scc_pkg::TGT_MAT;
			acc_q   <= ACC_W'(k_q[0][0]);
		end
	end

	// stores: entry loads and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < FIRST_DOFS; a++) begin
				for (int b = 0; b < FIRST_DOFS; b++) k_q[a][b] <= '0;
				for (int b = 0; b < SECOND_DOFS; b++) g_q[a][b] <= '0;
				fv_q[a] <= '0;
				dv_q[a] <= '0;
			end
			for (int a = 0; a < SECOND_DOFS; a++) begin
				for (int b = 0; b < SECOND_DOFS; b++) m_q[a][b] <= '0;
				hv_q[a] <= '0;
			end
		end else if (acc_in) begin
			unique case (cmd.kind)
				scc_pkg::KIND_K:
					if (int'(cmd.row) < FIRST_DOFS && int'(cmd.col) < FIRST_DOFS)
						k_q[cmd.row[N1_IW-1:0]][cmd.col[N1_IW-1:0]] <= cmd.value;
				scc_pkg::KIND_G:
					if (int'(cmd.row) < FIRST_DOFS && int'(cmd.col) < SECOND_DOFS)
						g_q[cmd.row[N1_IW-1:0]][cmd.col[N2_IW-1:0]] <= cmd.value;
				scc_pkg::KIND_M:
					if (int'(cmd.row) < SECOND_DOFS && int'(cmd.col) < SECOND_DOFS)
						m_q[cmd.row[N2_IW-1:0]][cmd.col[N2_IW-1:0]] <= cmd.value;
				scc_pkg::KIND_F:
					if (int'(cmd.row) < FIRST_DOFS)
						fv_q[cmd.row[N1_IW-1:0]] <= cmd.value;
				scc_pkg::KIND_H:
					if (int'(cmd.row) < SECOND_DOFS)
						hv_q[cmd.row[N2_IW-1:0]] <= cmd.value;
				scc_pkg::KIND_D:
					if (int'(cmd.row) < FIRST_DOFS)
						dv_q[cmd.row[N1_IW-1:0]] <= cmd.value;
				scc_pkg::KIND_CLEAR: begin
					for (int a = 0; a < FIRST_DOFS; a++) begin
						for (int b = 0; b < FIRST_DOFS; b++) k_q[a][b] <= '0;
						for (int b = 0; b < SECOND_DOFS; b++) g_q[a][b] <= '0;
						fv_q[a] <= '0;
						dv_q[a] <= '0;
					end
					for (int a = 0; a < SECOND_DOFS; a++) begin
						for (int b = 0; b < SECOND_DOFS; b++) m_q[a][b] <= '0;
						hv_q[a] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.valid    = res_valid_q;
	assign res.target   = res_tgt_q;
	assign res.out_row  = res_row_q;
	assign res.out_col  = res_col_q;
	assign res.result   = res_val_q;
	assign res.singular = res_sing_q;
	assign res.last     = res_last_q;

	`SCC_ASSERT_IMP(a_ready_div_idle, cmd.ready, !div_st.busy, "divider busy while taking words")
	`SCC_ASSERT_IMP(a_div_done_waited, div_st.done, state_q == scc_pkg::S_DIVW,
		"quotient finished outside its wait step")
	`SCC_ASSERT_IMP(a_word_from_emit, $rose(res_valid_q), $past(state_q) == scc_pkg::S_EMIT,
		"result word raised outside emit")
	`SCC_ASSERT(a_ready_idle_only, !(cmd.ready && state_q != scc_pkg::S_IDLE),
		"command words taken outside idle")

endmodule
